FILE: design/oale_pkg.sv
// Shared types and constants for the ordered array list engine.
// Depends on nothing; every other file of the block imports it.
package oale_pkg;

    // Operation codes carried in the op field of an input item.
    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_DEL_VAL = 3'd2,
        OP_FIND    = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    // Status codes reported with every result item.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Field widths and packed bus widths.
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                cap_value;
        logic                mem_rd;
        logic                mem_wr;
        logic                wr_value;
        logic                load_res;
        logic [STATUS_W-1:0] res_status;
        logic [POS_W-1:0]    res_fpos;
        logic                res_rval_en;
        logic [COUNT_W-1:0]  res_count;
    } dp_cmd_t;

endpackage

FILE: design/oale_datapath.sv
// Datapath of the ordered array list engine: entry memory, item value,
// read data register, match compare and the result register.
// Depends on oale_pkg.
module oale_datapath #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                           aclk,
    input  oale_pkg::dp_cmd_t              cmd,
    input  logic [AW-1:0]                  rd_addr,
    input  logic [AW-1:0]                  wr_addr,
    input  logic signed [oale_pkg::VAL_W-1:0] s_value,
    output logic                           match,
    output logic [oale_pkg::STATUS_W-1:0]  res_status,
    output logic [oale_pkg::POS_W-1:0]     res_fpos,
    output logic signed [oale_pkg::VAL_W-1:0] res_rval,
    output logic [oale_pkg::COUNT_W-1:0]   res_count
);
    import oale_pkg::*;

    logic [VAL_W-1:0] entry_mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] wdata;

    assign wdata = cmd.wr_value ? value_reg : rdata_reg;
    assign match = (rdata_reg == value_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            entry_mem[wr_addr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_value) begin
            value_reg <= s_value;
        end
        if (cmd.load_res) begin
            res_status <= cmd.res_status;
            res_fpos   <= cmd.res_fpos;
            res_rval   <= cmd.res_rval_en ? rdata_reg : '0;
            res_count  <= cmd.res_count;
        end
    end

endmodule

FILE: design/oale_ctrl.sv
// Controller of the ordered array list engine: holds the live count and
// sequences inserts, deletes, scans and reads over the entry memory.
// Depends on oale_pkg.
module oale_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [oale_pkg::OP_W-1:0]   s_op,
    input  logic [oale_pkg::POS_W-1:0]  s_pos,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        match,
    output oale_pkg::dp_cmd_t           cmd,
    output logic [AW-1:0]               rd_addr,
    output logic [AW-1:0]               wr_addr
);
    import oale_pkg::*;

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SHIFT_UP, S_INS_WRITE, S_SCAN, S_SHIFT_DN, S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       hit_reg, hit_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [XW-1:0] pos_x, cnt_x;
    logic [AW-1:0] pos_m1_a, cnt_m1_a, idx_p1, idx_m1;
    logic [CW-1:0] hit_now;
    logic          full, empty, last;

    assign pos_x    = XW'(pos_reg);
    assign cnt_x    = XW'(count_reg);
    assign pos_m1_a = AW'(pos_x - XW'(1));
    assign cnt_m1_a = AW'(count_reg - CW'(1));
    assign idx_p1   = idx_reg + AW'(1);
    assign idx_m1   = idx_reg - AW'(1);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last     = (idx_reg == cnt_m1_a);
    assign hit_now  = match ? (CW'(idx_reg) + CW'(1)) : hit_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        hit_next      = hit_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        rd_addr       = '0;
        wr_addr       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_value = 1'b1;
                    op_next       = s_op;
                    pos_next      = s_pos;
                    hit_next      = '0;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                status_next = ST_OK;
                state_next  = S_FINISH;
                unique case (op_reg) inside
                    OP_INSERT: begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                            status_next = ST_BADPOS;
                        end else if (pos_x == cnt_x + XW'(1)) begin
                            state_next = S_INS_WRITE;
                        end else begin
                            cmd.mem_rd = 1'b1;
                            rd_addr    = cnt_m1_a;
                            idx_next   = cnt_m1_a;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    OP_DELETE: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end else if (pos_x == '0 || pos_x > cnt_x) begin
                            status_next = ST_BADPOS;
                        end else if (pos_x == cnt_x) begin
                            count_next = count_reg - CW'(1);
                        end else begin
                            cmd.mem_rd = 1'b1;
                            rd_addr    = AW'(pos_x);
                            idx_next   = AW'(pos_x);
                            state_next = S_SHIFT_DN;
                        end
                    end
                    OP_DEL_VAL, OP_FIND: begin
                        if (empty) begin
                            status_next = (op_reg == OP_FIND) ? ST_NOTFOUND : ST_EMPTY;
                        end else begin
                            cmd.mem_rd = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    OP_READ: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end else if (pos_x == '0 || pos_x > cnt_x) begin
                            status_next = ST_BADPOS;
                        end else begin
                            cmd.mem_rd = 1'b1;
                            rd_addr    = pos_m1_a;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // Move the entry just read one place up, walking downward.
                cmd.mem_wr = 1'b1;
                wr_addr    = idx_p1;
                if (idx_reg == pos_m1_a) begin
                    state_next = S_INS_WRITE;
                end else begin
                    cmd.mem_rd = 1'b1;
                    rd_addr    = idx_m1;
                    idx_next   = idx_m1;
                end
            end
            S_INS_WRITE: begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_value = 1'b1;
                wr_addr      = pos_m1_a;
                count_next   = count_reg + CW'(1);
                state_next   = S_FINISH;
            end
            S_SCAN: begin
                hit_next = hit_now;
                if (!last) begin
                    cmd.mem_rd = 1'b1;
                    rd_addr    = idx_p1;
                    idx_next   = idx_p1;
                end else if (hit_now == '0) begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_FINISH;
                end else if (op_reg == OP_FIND || hit_now == count_reg) begin
                    // A find ends here; removing the last entry needs no shift.
                    if (op_reg != OP_FIND) begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_FINISH;
                end else begin
                    cmd.mem_rd = 1'b1;
                    rd_addr    = AW'(hit_now);
                    idx_next   = AW'(hit_now);
                    state_next = S_SHIFT_DN;
                end
            end
            S_SHIFT_DN: begin
                // Move the entry just read one place down, walking upward.
                cmd.mem_wr = 1'b1;
                wr_addr    = idx_m1;
                if (last) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end else begin
                    cmd.mem_rd = 1'b1;
                    rd_addr    = idx_p1;
                    idx_next   = idx_p1;
                end
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_res    = 1'b1;
                    cmd.res_status  = status_reg;
                    cmd.res_fpos    = (status_reg == ST_OK &&
                                       (op_reg == OP_FIND || op_reg == OP_DEL_VAL))
                                      ? POS_W'(hit_reg) : '0;
                    cmd.res_rval_en = (status_reg == ST_OK) && (op_reg == OP_READ);
                    cmd.res_count   = COUNT_W'(count_reg);
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            hit_reg      <= '0;
            idx_reg      <= '0;
            status_reg   <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            hit_reg      <= hit_next;
            idx_reg      <= idx_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: design/ordered_array_list_engine_core.sv
// Ordered array list engine: a list of up to DEPTH signed 32-bit entries kept
// in order with a live count. Each input item carries an op code (insert at a
// 1-based position, delete at a position, delete the last entry equal to a
// value, find the last entry equal to a value, read a position) and yields
// exactly one result item with a status, a found position, a read value and
// the count after the operation. Items are handled one at a time. Every walk
// over the list goes through the entry memory, which has one read and one
// write port, one entry per cycle. An insert shifts the entries from the
// position upward by one place, a delete at a position shifts the entries
// above it down, a find scans the whole list, and a delete by value scans
// the whole list and then shifts the entries above the hit down; a read or
// a refused operation needs no walk. A finished result waits in the output
// register while the next item is already taken in.
// Depends on oale_pkg, oale_ctrl and oale_datapath.
module ordered_array_list_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input item fields, from bit 0 up: op[2:0], position[7:3], value[39:8].
    input  logic [oale_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Result item fields, from bit 0 up: status[2:0], found_position[7:3],
    // read_value[39:8], entry_count_out[44:40], zero fill[47:45].
    output logic [oale_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import oale_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dp_cmd_t               cmd;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  match;
    logic [STATUS_W-1:0]   res_status;
    logic [POS_W-1:0]      res_fpos;
    logic signed [VAL_W-1:0] res_rval;
    logic [COUNT_W-1:0]    res_count;

    // Unpack the input item.
    logic [OP_W-1:0]         s_op;
    logic [POS_W-1:0]        s_position;
    logic signed [VAL_W-1:0] s_value;

    assign s_op       = s_tdata[2:0];
    assign s_position = s_tdata[7:3];
    assign s_value    = s_tdata[39:8];

    // The controller owns the count and the sequencing of every operation.
    oale_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_op),
        .s_pos    (s_position),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .match    (match),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    // The datapath holds the entries, the compare and the result register.
    oale_datapath #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .s_value    (s_value),
        .match      (match),
        .res_status (res_status),
        .res_fpos   (res_fpos),
        .res_rval   (res_rval),
        .res_count  (res_count)
    );

    // Pack the result item; the top bits are zero fill.
    assign m_tdata = {3'b000, res_count, res_rval, res_fpos, res_status};

endmodule

FILE: design/oale_checker.sv
// Port-level checker for the ordered array list engine, bound to the top.
// Depends on oale_pkg and ordered_array_list_engine_core.
module oale_checker #(
    parameter int DEPTH = 16
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [oale_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);
    import oale_pkg::*;

    // A result that is not taken holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result item changed while stalled");

    // Items are worked on one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A refused or failed operation reports no position and no value.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != ST_OK) |-> (m_tdata[39:3] == '0))
        else $error("failed operation carries position or value");

    // The count never exceeds the depth and the fill bits stay zero.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[44:40]) <= DEPTH && m_tdata[47:45] == 3'b000))
        else $error("reported count out of range");

endmodule

bind ordered_array_list_engine_core oale_checker #(.DEPTH(DEPTH)) u_oale_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
